FILE: design/srsp_pkg.sv
`timescale 1ns / 1ps
// srsp_pkg: types and constants shared by the skeleton record stream parser
// holds the item and result structs, the front-to-back command and the record layout
// no dependencies
package srsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [15:0] bone_number;
        logic [7:0]  element_number;
        logic [31:0] field_value;
        logic [2:0]  error_code;
        logic        last_of_run;
    } result_t;

    typedef enum logic [3:0] {
        KIND_HASH     = 4'd0,
        KIND_NAMELEN  = 4'd1,
        KIND_NAMECHAR = 4'd2,
        KIND_PARENT   = 4'd3,
        KIND_BIND     = 4'd4,
        KIND_INVBIND  = 4'd5,
        KIND_SCALE    = 4'd6,
        KIND_ROT      = 4'd7,
        KIND_POS      = 4'd8,
        KIND_COUNT    = 4'd9,
        KIND_END      = 4'd10,
        KIND_ERROR    = 4'd11
    } field_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_HEADER   = 3'd1,
        ERR_COUNT_RANGE  = 3'd2,
        ERR_RECORD_TRUNC = 3'd3,
        ERR_NAME_TRUNC   = 3'd4,
        ERR_BAD_PARENT   = 3'd5
    } error_code_t;

    // one accepted byte: an optional field and an optional closing end or error
    typedef struct packed {
        logic        f_valid;
        field_kind_t f_kind;
        logic [15:0] f_bone;
        logic [7:0]  f_elem;
        logic [31:0] f_value;
        logic        t_valid;
        field_kind_t t_kind;
        error_code_t t_err;
        logic [15:0] t_bone;
    } cmd_t;

    localparam logic [7:0] MAGIC [4] = '{8'h50, 8'h41, 8'h52, 8'h20};

    localparam logic [9:0]  COUNT_OFFSET = 10'h014;
    localparam logic [15:0] COUNT_BAD    = 16'hFFFF;
    localparam logic [9:0]  NAME_START   = 10'd5;
    localparam logic [7:0]  PRINT_LO     = 8'h20;
    localparam logic [7:0]  PRINT_HI     = 8'h7E;
    localparam logic [7:0]  SUBST_CHAR   = 8'h3F;

    // offsets counted from the end of the name
    localparam logic [9:0]  Q_BIND    = 10'd4;
    localparam logic [9:0]  Q_INVBIND = 10'd68;
    localparam logic [9:0]  Q_COPY    = 10'd132;
    localparam logic [9:0]  Q_SCALE   = Q_COPY + 10'd128;
    localparam logic [9:0]  Q_ROT     = 10'd272;
    localparam logic [9:0]  Q_POS     = 10'd288;
    localparam logic [9:0]  Q_LAST    = 10'd299;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

FILE: design/skeleton_record_stream_parser_top.sv
`timescale 1ns / 1ps
// skeleton_record_stream_parser_top: skeleton file byte parser, top level
// joins srsp_front, srsp_queue and srsp_back; depends on srsp_pkg
//
// input side is a queue: drive item and push; a byte is taken at a clock edge
// with push high and full low. item.end_of_file marks the last byte of a file,
// after which the parser rearms for the next file.
// result side is a queue: while empty is low the oldest result sits on result
// and is taken at an edge with pop high.
// throughput: one byte per cycle while full is low.
// a taken byte's command is written into the command queue, the back moves it
// into the output register, and the result then sits on the ports until popped.
// a byte that closes a file can give two results; the back issues one per
// cycle while pop keeps pace, from a four-entry command queue, so full rises
// only when the result side stalls or falls behind.
// when pop stays low the output register holds, the queue fills and full rises.
// reset: rst_n clears position, counts and queues; the parser waits for the
// magic of a new file and empty stays high.
module skeleton_record_stream_parser_top
    import srsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic wr_en;
    cmd_t wr_cmd;
    logic rd_en;
    cmd_t head;
    logic avail;

    srsp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .wr_en (wr_en),
        .cmd   (wr_cmd)
    );

    srsp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_cmd),
        .rd_en   (rd_en),
        .rd_data (head),
        .avail   (avail),
        .full    (full)
    );

    srsp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .avail  (avail),
        .rd_en  (rd_en),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

FILE: design/srsp_front.sv
`timescale 1ns / 1ps
// srsp_front: accepts file bytes, tracks header and record position, classifies each byte
// emits one command per byte that produces results
// depends on srsp_pkg
module srsp_front
    import srsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  logic  full,
    input  item_t item,
    output logic  wr_en,
    output cmd_t  cmd
);

    typedef enum logic {PH_HEADER, PH_RECORD} phase_t;

    phase_t      phase_reg, phase_next;
    logic [9:0]  pos_reg, pos_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] bone_reg, bone_next;
    logic [7:0]  name_len_reg, name_len_next;
    logic [23:0] word_reg, word_next;
    logic [31:0] parent_reg, parent_next;
    logic        done_reg, done_next;
    logic        accept;

    assign accept = push && !full;

    always_comb
    begin
        logic [31:0] word;
        logic [9:0]  name_end;
        logic [9:0]  q;
        logic [9:0]  name_idx;
        logic [9:0]  base;
        logic [9:0]  off;
        logic [15:0] count_val;
        logic [15:0] bone_inc;
        logic [7:0]  ch;
        logic        parent_ok;

        word      = {item.data_byte, word_reg};
        name_end  = NAME_START + {2'b00, name_len_reg};
        q         = pos_reg - name_end;
        name_idx  = pos_reg - NAME_START;
        count_val = {item.data_byte, total_reg[7:0]};
        bone_inc  = bone_reg + 16'd1;
        ch        = (item.data_byte inside {[PRINT_LO:PRINT_HI]}) ? item.data_byte : SUBST_CHAR;
        parent_ok = (parent_reg == '1) || (parent_reg < {16'd0, total_reg});
        base      = Q_BIND;
        off       = '0;

        phase_next    = phase_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        bone_next     = bone_reg;
        name_len_next = name_len_reg;
        word_next     = word_reg;
        parent_next   = parent_reg;
        done_next     = done_reg;

        cmd        = '0;
        cmd.f_bone = bone_reg;
        cmd.t_bone = bone_reg;
        cmd.t_kind = KIND_ERROR;

        if (accept && !done_reg)
        begin
            if (phase_reg == PH_HEADER)
            begin
                if (pos_reg < 10'd4 && item.data_byte != MAGIC[pos_reg[1:0]])
                begin
                    cmd.t_valid = 1'b1;
                    cmd.t_err   = ERR_BAD_HEADER;
                    done_next   = 1'b1;
                end
                else if (pos_reg == COUNT_OFFSET + 10'd1)
                begin
                    total_next    = count_val;
                    cmd.f_valid   = 1'b1;
                    cmd.f_kind    = KIND_COUNT;
                    cmd.f_value   = {16'd0, count_val};
                    if (count_val == COUNT_BAD)
                    begin
                        cmd.t_valid = 1'b1;
                        cmd.t_err   = ERR_COUNT_RANGE;
                        done_next   = 1'b1;
                    end
                    else if (count_val == 16'd0)
                    begin
                        cmd.t_valid = 1'b1;
                        cmd.t_kind  = KIND_END;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RECORD;
                        pos_next   = '0;
                        if (item.end_of_file)
                        begin
                            cmd.t_valid = 1'b1;
                            cmd.t_err   = ERR_RECORD_TRUNC;
                        end
                    end
                end
                else
                begin
                    if (pos_reg == COUNT_OFFSET)
                    begin
                        total_next = {8'd0, item.data_byte};
                    end
                    pos_next = pos_reg + 10'd1;
                    if (item.end_of_file)
                    begin
                        cmd.t_valid = 1'b1;
                        cmd.t_err   = ERR_BAD_HEADER;
                    end
                end
            end
            else
            begin
                word_next = word[31:8];
                pos_next  = pos_reg + 10'd1;
                if (pos_reg < 10'd4)
                begin
                    if (pos_reg == 10'd3)
                    begin
                        cmd.f_valid = 1'b1;
                        cmd.f_kind  = KIND_HASH;
                        cmd.f_value = word;
                    end
                end
                else if (pos_reg == 10'd4)
                begin
                    name_len_next = item.data_byte;
                    cmd.f_valid   = 1'b1;
                    cmd.f_kind    = KIND_NAMELEN;
                    cmd.f_value   = {24'd0, item.data_byte};
                end
                else if (pos_reg < name_end)
                begin
                    cmd.f_valid = 1'b1;
                    cmd.f_kind  = KIND_NAMECHAR;
                    cmd.f_elem  = name_idx[7:0];
                    cmd.f_value = {24'd0, ch};
                end
                else
                begin
                    cmd.f_value = word;
                    if (q < Q_BIND)
                    begin
                        cmd.f_kind = KIND_PARENT;
                    end
                    else if (q < Q_INVBIND)
                    begin
                        cmd.f_kind = KIND_BIND;
                    end
                    else if (q < Q_COPY)
                    begin
                        cmd.f_kind = KIND_INVBIND;
                        base       = Q_INVBIND;
                    end
                    else if (q < Q_SCALE)
                    begin
                        cmd.f_kind = KIND_HASH;
                    end
                    else if (q < Q_ROT)
                    begin
                        cmd.f_kind = KIND_SCALE;
                        base       = Q_SCALE;
                    end
                    else if (q < Q_POS)
                    begin
                        cmd.f_kind = KIND_ROT;
                        base       = Q_ROT;
                    end
                    else
                    begin
                        cmd.f_kind = KIND_POS;
                        base       = Q_POS;
                    end
                    off = q - base;
                    if (q[1:0] == 2'b11 && !(q >= Q_COPY && q < Q_SCALE))
                    begin
                        cmd.f_valid = 1'b1;
                        if (q >= Q_BIND)
                        begin
                            cmd.f_elem = off[9:2];
                        end
                        if (q < Q_BIND)
                        begin
                            parent_next = word;
                        end
                    end
                end

                if (pos_reg >= name_end && q >= Q_LAST)
                begin
                    cmd.t_valid = 1'b1;
                    if (!parent_ok)
                    begin
                        cmd.t_err = ERR_BAD_PARENT;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        bone_next     = bone_inc;
                        pos_next      = '0;
                        name_len_next = '0;
                        cmd.t_bone    = bone_inc;
                        if (bone_inc == total_reg)
                        begin
                            cmd.t_kind = KIND_END;
                            done_next  = 1'b1;
                        end
                        else if (item.end_of_file)
                        begin
                            cmd.t_err = ERR_RECORD_TRUNC;
                        end
                        else
                        begin
                            cmd.t_valid = 1'b0;
                        end
                    end
                end
                else if (item.end_of_file)
                begin
                    // a record cut short: the file ends before the record's last byte
                    cmd.t_valid = 1'b1;
                    cmd.t_err   = ERR_RECORD_TRUNC;
                end
            end
        end

        if (accept && item.end_of_file)
        begin
            phase_next    = PH_HEADER;
            pos_next      = '0;
            total_next    = '0;
            bone_next     = '0;
            name_len_next = '0;
            done_next     = 1'b0;
        end
    end

    assign wr_en = accept && (cmd.f_valid || cmd.t_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            total_reg    <= '0;
            bone_reg     <= '0;
            name_len_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            total_reg    <= total_next;
            bone_reg     <= bone_next;
            name_len_reg <= name_len_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        parent_reg <= parent_next;
    end

    a_terminal_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && cmd.t_valid && !item.end_of_file) |=> done_reg)
        else $error("closing result without finishing the file");

    a_header_no_bones: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (bone_reg == '0))
        else $error("bone count advanced inside the header");

    a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !wr_en)
        else $error("command issued after end or error");

endmodule

FILE: design/srsp_queue.sv
`timescale 1ns / 1ps
// srsp_queue: short first-word-fall-through queue of commands between front and back
// depends on srsp_pkg
module srsp_queue
    import srsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic avail,
    output logic full
);

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> avail)
        else $error("command read from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: design/srsp_back.sv
`timescale 1ns / 1ps
// srsp_back: takes commands from the queue and issues their results one item at a time
// holds the output register seen by the result side
// depends on srsp_pkg
module srsp_back
    import srsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head,
    input  logic    avail,
    output logic    rd_en,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    result_t res_reg, res_next;
    logic    valid_reg, valid_next;
    logic    second_reg, second_next;
    logic    load;

    assign load  = avail && (!valid_reg || pop);
    assign empty = !valid_reg;

    always_comb
    begin
        res_next    = res_reg;
        second_next = second_reg;
        rd_en       = 1'b0;
        valid_next  = load || (valid_reg && !pop);
        if (load)
        begin
            if (head.f_valid && !second_reg)
            begin
                res_next.field_kind     = head.f_kind;
                res_next.bone_number    = head.f_bone;
                res_next.element_number = head.f_elem;
                res_next.field_value    = head.f_value;
                res_next.error_code     = ERR_NONE;
                res_next.last_of_run    = 1'b0;
                if (head.t_valid)
                begin
                    second_next = 1'b1;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            else
            begin
                res_next.field_kind     = head.t_kind;
                res_next.bone_number    = head.t_bone;
                res_next.element_number = '0;
                res_next.field_value    = '0;
                res_next.error_code     = head.t_err;
                res_next.last_of_run    = 1'b1;
                rd_en                   = 1'b1;
                second_next             = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;

    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (avail && head.f_valid && head.t_valid))
        else $error("closing result pending without its command");

endmodule
